FILE: rtl/core/utcl_pkg.sv
// Package for the UTF-8 text cursor layout block.
// Register indexes, configuration and state structs, decode constants.
// No dependencies.
package utcl_pkg;

	localparam int unsigned XW      = 10;
	localparam int unsigned YW      = 12;
	localparam int unsigned SYW     = 9;
	localparam int unsigned STEPW   = 8;
	localparam int unsigned CODEW   = 32;
	localparam int unsigned ACCW    = 24;
	localparam int unsigned CFG_IW  = 3;
	localparam int unsigned CFG_DW  = 10;

	localparam logic [YW-1:0] Y_MAX = 12'hFFF;

	localparam logic [7:0] NEWLINE  = 8'h0A;
	localparam logic [7:0] LEAD2_LO = 8'hC0;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF7;

	// upper twelve code bits of the double-width range 0xE00000..0xEFFFFF
	localparam logic [11:0] WIDE_TOP = 12'h00E;

	localparam logic [XW-1:0]    START_X_RST = 10'd0;
	localparam logic [SYW-1:0]   START_Y_RST = 9'd0;
	localparam logic [XW-1:0]    END_X_RST   = 10'd799;
	localparam logic [STEPW-1:0] STEP_X_RST  = 8'd8;
	localparam logic [STEPW-1:0] STEP_Y_RST  = 8'd16;

	typedef enum logic [CFG_IW-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_END_X   = 3'd2,
		REG_STEP_X  = 3'd3,
		REG_STEP_Y  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [XW-1:0]    start_x;
		logic [SYW-1:0]   start_y;
		logic [XW-1:0]    end_x;
		logic [STEPW-1:0] step_x;
		logic [STEPW-1:0] step_y;
	} cfg_t;

	typedef struct packed {
		logic [XW-1:0]   cursor_x;
		logic [YW-1:0]   cursor_y;
		logic [ACCW-1:0] code_accum;
		logic [1:0]      bytes_left;
	} state_t;

	typedef struct packed {
		logic [XW-1:0]    draw_x;
		logic [YW-1:0]    draw_y;
		logic [CODEW-1:0] char_code;
		logic             double_width;
	} result_t;

endpackage

FILE: rtl/core/utcl_cfg.sv
// Configuration register file for the text cursor layout block.
// Depends on utcl_pkg.
module utcl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [utcl_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [utcl_pkg::CFG_DW-1:0]   cfg_data,
	output utcl_pkg::cfg_t                cfg
);
	import utcl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x <= START_X_RST;
			cfg_q.start_y <= START_Y_RST;
			cfg_q.end_x   <= END_X_RST;
			cfg_q.step_x  <= STEP_X_RST;
			cfg_q.step_y  <= STEP_Y_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_START_X: cfg_q.start_x <= cfg_data[XW-1:0];
				REG_START_Y: cfg_q.start_y <= cfg_data[SYW-1:0];
				REG_END_X:   cfg_q.end_x   <= cfg_data[XW-1:0];
				REG_STEP_X:  cfg_q.step_x  <= cfg_data[STEPW-1:0];
				REG_STEP_Y:  cfg_q.step_y  <= cfg_data[STEPW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/utcl_step.sv
// Per-byte next-state logic: UTF-8 assembly, newline, draw result, cursor advance.
// Purely combinational. Depends on utcl_pkg.
module utcl_step (
	input  utcl_pkg::cfg_t    cfg,
	input  utcl_pkg::state_t  cur,
	input  logic [7:0]        text_byte,
	input  logic              string_start,
	output utcl_pkg::state_t  nxt,
	output logic              emit,
	output utcl_pkg::result_t res
);
	import utcl_pkg::*;

	logic [XW-1:0]    cx;
	logic [YW-1:0]    cy;
	logic [ACCW-1:0]  acc;
	logic [1:0]       left;
	logic [1:0]       lead_len;
	logic [1:0]       nleft;
	logic [CODEW-1:0] code;
	logic             complete;
	logic             newline;
	logic             wide;
	logic [STEPW:0]   adv;
	logic [XW:0]      nx;
	logic             wrap;
	logic [YW:0]      ysum;
	logic [YW-1:0]    ysat;
	logic             line_feed;

	always_comb begin
		case (text_byte) inside
			[LEAD2_LO:LEAD2_HI]: lead_len = 2'd1;
			[LEAD3_LO:LEAD3_HI]: lead_len = 2'd2;
			[LEAD4_LO:LEAD4_HI]: lead_len = 2'd3;
			default:             lead_len = 2'd0;
		endcase
	end

	always_comb begin
		cx   = string_start ? cfg.start_x : cur.cursor_x;
		cy   = string_start ? {{(YW-SYW){1'b0}}, cfg.start_y} : cur.cursor_y;
		acc  = string_start ? '0 : cur.code_accum;
		left = string_start ? 2'd0 : cur.bytes_left;

		if (left != 2'd0) begin
			code  = {acc, text_byte};
			nleft = left - 2'd1;
		end else begin
			code  = {{(CODEW-8){1'b0}}, text_byte};
			nleft = lead_len;
		end
		complete = (nleft == 2'd0);
		newline  = complete && (left == 2'd0) && (text_byte == NEWLINE);
		emit     = complete && !newline;

		wide = (code[CODEW-1:CODEW-12] == WIDE_TOP);
		adv  = wide ? {cfg.step_x, 1'b0} : {1'b0, cfg.step_x};
		nx   = {1'b0, cx} + {{(XW-STEPW){1'b0}}, adv};
		wrap = (nx > {1'b0, cfg.end_x});

		ysum = {1'b0, cy} + {{(YW+1-STEPW){1'b0}}, cfg.step_y};
		ysat = ysum[YW] ? Y_MAX : ysum[YW-1:0];

		line_feed = newline || (emit && wrap);

		nxt.cursor_x   = line_feed ? cfg.start_x : (emit ? nx[XW-1:0] : cx);
		nxt.cursor_y   = line_feed ? ysat : cy;
		nxt.code_accum = complete ? '0 : code[ACCW-1:0];
		nxt.bytes_left = nleft;

		res.draw_x       = cx;
		res.draw_y       = cy;
		res.char_code    = code;
		res.double_width = wide;
	end

endmodule

FILE: rtl/core/utf8_text_cursor_layout.sv
// Top level of the UTF-8 text cursor layout block.
// Input register, step logic, result register. Depends on utcl_pkg, utcl_cfg, utcl_step.
//
//   port group   handshake            payload
//   input        in_valid/in_ready    text_byte, string_start
//   result       out_valid/out_ready  draw_x, draw_y, char_code, double_width
//   config       cfg_we               cfg_index, cfg_data
//
// One byte per cycle sustained while no result is held; a result passes from the input
// register into the result register when its last byte advances out of the input register.
// Reset clears cursor to (0,0), the partial character and the config registers to defaults.
// A byte that draws waits in the input register while the result register is
// held; bytes that draw nothing pass through regardless.
module utf8_text_cursor_layout (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          text_byte,
	input  logic                                string_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [utcl_pkg::XW-1:0]             draw_x,
	output logic [utcl_pkg::YW-1:0]             draw_y,
	output logic [utcl_pkg::CODEW-1:0]          char_code,
	output logic                                double_width,
	input  logic                                cfg_we,
	input  logic [utcl_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [utcl_pkg::CFG_DW-1:0]         cfg_data
);
	import utcl_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_q;
	logic    emit;
	logic    valid_s1;
	logic    valid_out_q;
	logic    advance;
	logic [7:0] byte_s1;
	logic       start_s1;

	utcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	utcl_step u_step (
		.cfg          (cfg),
		.cur          (state_q),
		.text_byte    (byte_s1),
		.string_start (start_s1),
		.nxt          (state_nxt),
		.emit         (emit),
		.res          (res)
	);

	assign advance  = valid_s1 && (!emit || !valid_out_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= text_byte;
			start_s1 <= string_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else if (advance && emit) begin
			valid_out_q <= 1'b1;
		end else if (out_ready) begin
			valid_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_out_q;
	assign draw_x       = res_q.draw_x;
	assign draw_y       = res_q.draw_y;
	assign char_code    = res_q.char_code;
	assign double_width = res_q.double_width;

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_out_q && !out_ready))
		else $error("input stalled without a held result");

	// no partial character pending means nothing accumulated
	a_accum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.bytes_left == 2'd0) |-> (state_q.code_accum == '0))
		else $error("stale accumulated code");

	// wide flag only for three-byte codes
	a_wide_code: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out_q && res_q.double_width) |-> (res_q.char_code[CODEW-1:ACCW] == '0))
		else $error("double width on out-of-range code");

endmodule
